// ===== hdl/slrg_pkg.sv =====
`timescale 1ns / 1ps

package slrg_pkg;

  // Generator arithmetic
  localparam int VAL_W  = 31;
  localparam int MUL_W  = 15;
  localparam int PROD_W = VAL_W + MUL_W;

  localparam logic [VAL_W-1:0] LEHMER_MOD = 31'h7FFF_FFFF;
  localparam logic [MUL_W-1:0] LEHMER_MUL = 15'd16807;
  localparam logic [VAL_W-1:0] SEED_RESET = 31'd15;

  // Sequencer program counter
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // Datapath operation selected by the current control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD_SEED,
    OP_SEED_MUL,
    OP_SEED_RED,
    OP_DRAW_MUL,
    OP_DRAW_FIN
  } op_t;

  // Jump condition; the jump is taken when the condition holds
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NO_SEED,
    C_CNT_NZ,
    C_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  // Status flags from the datapath back to the sequencer
  typedef struct packed {
    logic accept;
    logic need_seed;
    logic cnt_nz;
    logic out_busy;
  } stat_t;

  // Program step addresses
  localparam pc_t PC_IDLE  = 4'd0;
  localparam pc_t PC_CHECK = 4'd1;
  localparam pc_t PC_LOAD  = 4'd2;
  localparam pc_t PC_SMUL  = 4'd3;
  localparam pc_t PC_SRED  = 4'd4;
  localparam pc_t PC_DMUL  = 4'd5;
  localparam pc_t PC_DFIN  = 4'd6;

  // Control store
  function automatic ctrl_t ucode_rom(pc_t pc);
    ctrl_t w;
    case (pc)
      PC_IDLE:  w = '{op: OP_ACCEPT,    cond: C_NO_ACCEPT, target: PC_IDLE};
      PC_CHECK: w = '{op: OP_NONE,      cond: C_NO_SEED,   target: PC_DMUL};
      PC_LOAD:  w = '{op: OP_LOAD_SEED, cond: C_NEXT,      target: PC_IDLE};
      PC_SMUL:  w = '{op: OP_SEED_MUL,  cond: C_NEXT,      target: PC_IDLE};
      PC_SRED:  w = '{op: OP_SEED_RED,  cond: C_CNT_NZ,    target: PC_SMUL};
      PC_DMUL:  w = '{op: OP_DRAW_MUL,  cond: C_OUT_BUSY,  target: PC_DMUL};
      PC_DFIN:  w = '{op: OP_DRAW_FIN,  cond: C_ALWAYS,    target: PC_IDLE};
      default:  w = '{op: OP_NONE,      cond: C_ALWAYS,    target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/shuffled_lehmer_random_generator.sv =====
`timescale 1ns / 1ps
// A plain draw runs the accept, check, table read and finish steps in order; a new
// request is taken only once the previous draw has finished, and a result still waiting
// holds the program at the table read step until the consumer takes it.
// A seeding draw first loads the seed and runs TABLE_DEPTH + 8 warm-up steps: each
// warm-up step uses the multiplier, then the modular fold. Reset (synchronous, low)
// clears the generator state so the first request always seeds; the seed register is 15.

module shuffled_lehmer_random_generator
  import slrg_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_reseed,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_random_value,
  input  logic             cfg_write_en,
  input  logic [VAL_W-1:0] cfg_seed_value
);

  ctrl_t ctrl;
  stat_t stat;

  // Program sequencer
  slrg_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  // Generator, shuffle table and selector datapath
  slrg_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .stat             (stat),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_reseed        (in_reseed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_random_value (out_random_value),
    .cfg_write_en     (cfg_write_en),
    .cfg_seed_value   (cfg_seed_value)
  );

endmodule

// ===== hdl/slrg_seq.sv =====
`timescale 1ns / 1ps

module slrg_seq
  import slrg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t stat,
  output ctrl_t ctrl
);

  pc_t  pc_r;
  pc_t  pc_nxt;
  logic jump;

  // Fetch the control word for the current step
  assign ctrl = ucode_rom(pc_r);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      C_NEXT:      jump = 1'b0;
      C_ALWAYS:    jump = 1'b1;
      C_NO_ACCEPT: jump = !stat.accept;
      C_NO_SEED:   jump = !stat.need_seed;
      C_CNT_NZ:    jump = stat.cnt_nz;
      C_OUT_BUSY:  jump = stat.out_busy;
      default:     jump = 1'b1;
    endcase
  end

  // Advance or jump
  always_comb begin
    pc_nxt = jump ? ctrl.target : pc_r + pc_t'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

// ===== hdl/slrg_lehmer.sv =====
`timescale 1ns / 1ps

module slrg_lehmer
  import slrg_pkg::*;
(
  input  logic             clk,
  input  logic             mul_en,
  input  logic [VAL_W-1:0] x,
  output logic [VAL_W-1:0] x_next
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [VAL_W:0]    fold;
  logic [VAL_W:0]    fold_sub;

  // Multiply by the constant multiplier
  always_comb begin
    prod_nxt = prod_r;
    if (mul_en) begin
      prod_nxt = PROD_W'(x) * PROD_W'(LEHMER_MUL);
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Fold the high part onto the low part, then subtract the modulus once
  always_comb begin
    fold     = {1'b0, prod_r[VAL_W-1:0]} + (VAL_W+1)'(prod_r[PROD_W-1:VAL_W]);
    fold_sub = fold - {1'b0, LEHMER_MOD};
    x_next   = (fold >= {1'b0, LEHMER_MOD}) ? fold_sub[VAL_W-1:0] : fold[VAL_W-1:0];
  end

endmodule

// ===== hdl/slrg_datapath.sv =====
`timescale 1ns / 1ps

module slrg_datapath
  import slrg_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_t            ctrl,
  output stat_t            stat,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_reseed,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAL_W-1:0] out_random_value,
  input  logic             cfg_write_en,
  input  logic [VAL_W-1:0] cfg_seed_value
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
  localparam int unsigned DIVISOR = 1 + 2147483646 / TABLE_DEPTH;
  localparam logic [31:0] DIV_W32 = 32'(DIVISOR);

  logic [VAL_W-1:0] seed_r, seed_nxt;
  logic [VAL_W-1:0] x_r, x_nxt;
  logic [VAL_W-1:0] prev_r, prev_nxt;
  logic [VAL_W-1:0] out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             do_seed_r, do_seed_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0] rd_r;

  logic [VAL_W-1:0] tbl_mem [TABLE_DEPTH];

  logic             accept;
  logic [VAL_W-1:0] x_step;
  logic [VAL_W-1:0] seed_start;
  logic [AW-1:0]    sel;
  logic             tbl_we;
  logic [AW-1:0]    tbl_wa;
  logic [VAL_W-1:0] tbl_wd;

  // Request handshake
  assign in_ready = (ctrl.op == OP_ACCEPT);
  assign accept   = in_ready && in_valid;

  // Status back to the sequencer
  assign stat.accept    = accept;
  assign stat.need_seed = do_seed_r;
  assign stat.cnt_nz    = (cnt_r != '0);
  assign stat.out_busy  = out_valid_r && !out_ready;

  assign out_valid        = out_valid_r;
  assign out_random_value = out_r;

  slrg_lehmer u_lehmer (
    .clk    (clk),
    .mul_en ((ctrl.op == OP_SEED_MUL) || (ctrl.op == OP_DRAW_MUL)),
    .x      (x_r),
    .x_next (x_step)
  );

  // Zero seed and a seed equal to the modulus both start from one
  assign seed_start = ((seed_r == '0) || (seed_r == LEHMER_MOD)) ? VAL_W'(1) : seed_r;

  // Select the table entry by comparing the previous output with fixed bucket bounds
  always_comb begin
    sel = '0;
    for (int k = 1; k < TABLE_DEPTH; k++) begin
      if ({1'b0, prev_r} >= DIV_W32 * 32'(k)) begin
        sel = AW'(k);
      end
    end
  end

  // Shuffle table write port
  always_comb begin
    tbl_we = 1'b0;
    tbl_wa = cnt_r[AW-1:0];
    tbl_wd = x_step;
    if (ctrl.op == OP_SEED_RED) begin
      tbl_we = (cnt_r < CNT_W'(TABLE_DEPTH));
    end else if (ctrl.op == OP_DRAW_FIN) begin
      tbl_we = 1'b1;
      tbl_wa = sel;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_wa] <= tbl_wd;
    end
    if (ctrl.op == OP_DRAW_MUL) begin
      rd_r <= tbl_mem[sel];
    end
  end

  // Next-value logic for state and working registers
  always_comb begin
    seed_nxt      = cfg_write_en ? cfg_seed_value : seed_r;
    x_nxt         = x_r;
    prev_nxt      = prev_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    do_seed_nxt   = do_seed_r;
    cnt_nxt       = cnt_r;
    case (ctrl.op)
      OP_ACCEPT: begin
        if (accept) begin
          do_seed_nxt = in_reseed || (x_r == '0) || (prev_r == '0);
        end
      end
      OP_LOAD_SEED: begin
        x_nxt   = seed_start;
        cnt_nxt = CNT_W'(TABLE_DEPTH + 7);
      end
      OP_SEED_RED: begin
        x_nxt   = x_step;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          prev_nxt = x_step;
        end
      end
      OP_DRAW_FIN: begin
        x_nxt         = x_step;
        prev_nxt      = rd_r;
        out_nxt       = rd_r;
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= SEED_RESET;
      x_r         <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
      do_seed_r   <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      x_r         <= x_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
      do_seed_r   <= do_seed_nxt;
    end
  end

  // Payload and loop registers
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb
  import slrg_pkg::*;
();

  localparam int TBL_DEPTH = 32;
  localparam logic [VAL_W-1:0] SEED_MAX = 31'h7FFF_FFFE;
  localparam logic [VAL_W-1:0] SEED_ONE = 31'd1;
  localparam logic [VAL_W-1:0] SEED_ZERO = 31'd0;
  localparam int REPORT_LIMIT = 10;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic             in_reseed;
  logic             out_valid;
  logic             out_ready;
  logic [VAL_W-1:0] out_random_value;
  logic             cfg_write_en;
  logic [VAL_W-1:0] cfg_seed_value;

  // no idling on either side while set
  bit steady;

  // Shadow of the shuffled generator plus the queue of draws still owed
  class draw_tracker;
    bit [VAL_W-1:0] seed_reg;
    bit [VAL_W-1:0] gen_state;
    bit [VAL_W-1:0] last_out;
    bit [VAL_W-1:0] shuffle[TBL_DEPTH];
    bit [VAL_W-1:0] expected_draws[$];
    int mismatches;
    int checked;
    int seedings;

    function new();
      seed_reg = SEED_RESET;
      gen_state = '0;
      last_out = '0;
      foreach (shuffle[i]) shuffle[i] = '0;
      mismatches = 0;
      checked = 0;
      seedings = 0;
    endfunction

    function bit [VAL_W-1:0] lehmer_step(bit [VAL_W-1:0] x);
      bit [63:0] prod;
      prod = 64'(x) * 64'(LEHMER_MUL);
      return VAL_W'(prod % 64'(LEHMER_MOD));
    endfunction

    // Warm up from the seed register and fill the table top down
    function void refill_table();
      bit [VAL_W-1:0] x;
      x = seed_reg;
      if (x == '0 || x == LEHMER_MOD) x = SEED_ONE;
      for (int n = TBL_DEPTH + 7; n >= 0; n--) begin
        x = lehmer_step(x);
        if (n < TBL_DEPTH) shuffle[n] = x;
      end
      gen_state = x;
      last_out = shuffle[0];
      seedings++;
    endfunction

    // Predict the draw caused by an accepted request
    function void note_request(bit reseed);
      int unsigned divisor;
      int unsigned sel;
      divisor = 1 + (32'(LEHMER_MOD) - 1) / TBL_DEPTH;
      if (reseed || gen_state == '0 || last_out == '0) refill_table();
      gen_state = lehmer_step(gen_state);
      sel = 32'(last_out) / divisor;
      if (sel >= TBL_DEPTH) sel = TBL_DEPTH - 1;
      last_out = shuffle[sel];
      shuffle[sel] = gen_state;
      expected_draws.push_back(last_out);
    endfunction

    // Compare a delivered draw with the oldest prediction
    function void check_draw(bit [VAL_W-1:0] got);
      bit [VAL_W-1:0] want;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected draw %0d with nothing pending", $realtime, got);
        return;
      end
      want = expected_draws.pop_front();
      checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: draw %0d random_value expected %0d got %0d",
                   $realtime, checked, want, got);
      end
    endfunction
  endclass

  draw_tracker tracker;
  int seed_settings;

  shuffled_lehmer_random_generator #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_reseed       (in_reseed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_random_value(out_random_value),
    .cfg_write_en    (cfg_write_en),
    .cfg_seed_value  (cfg_seed_value)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Present one request and hold it until it is taken
  task automatic send_request(input bit reseed);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_reseed <= reseed;
    do @(posedge clk); while (!in_ready);
    tracker.note_request(reseed);
    @(negedge clk);
  endtask

  // Drop the request line and wait for every owed draw
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_draws.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_seed(input logic [VAL_W-1:0] value);
    cfg_seed_value <= value;
    cfg_write_en <= 1'b1;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    tracker.seed_reg = value;
    seed_settings++;
    @(negedge clk);
  endtask

  // Check every draw taken by the consumer
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) tracker.check_draw(out_random_value);
  end

  // Consumer stalls in random runs
  initial begin
    int run_left;
    bit level;
    run_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) begin
          level = 1'b1;
          run_left = $urandom_range(1, 8);
        end else if (r < 92) begin
          level = 1'b0;
          run_left = $urandom_range(1, 3);
        end else begin
          level = 1'b0;
          run_left = $urandom_range(10, 40);
        end
      end
      run_left--;
      out_ready <= level;
    end
  end

  // Hard stop
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    int odds;
    int pick;
    logic [VAL_W-1:0] seed;
    tracker = new();
    seed_settings = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_reseed = 1'b0;
    cfg_write_en = 1'b0;
    cfg_seed_value = '0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First request seeds from the reset value even without reseed
    send_request(1'b0);
    repeat (3) send_request(1'b0);
    send_request(1'b1);
    drain();

    // Zero seed, seed equal to the modulus, largest seed, seed of one
    write_seed(SEED_ZERO);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_seed(LEHMER_MOD);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_seed(SEED_MAX);
    send_request(1'b1);
    send_request(1'b0);
    drain();
    write_seed(SEED_ONE);
    send_request(1'b1);
    repeat (2) send_request(1'b0);
    drain();

    // New seed takes effect only on the next reseed
    write_seed(VAL_W'($urandom));
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    drain();

    // Random phases: long unseeded runs walk deep into the table
    for (int phase = 0; phase < 10; phase++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       seed = SEED_ZERO;
        1:       seed = LEHMER_MOD;
        2:       seed = SEED_MAX;
        3:       seed = SEED_ONE;
        default: seed = VAL_W'($urandom);
      endcase
      write_seed(seed);
      steady = (phase % 3 == 0);
      odds = (phase % 4 == 1) ? 4 : 40;
      send_request($urandom_range(0, 3) != 0);
      for (int i = 1; i < 125; i++)
        send_request($urandom_range(0, odds - 1) == 0);
      drain();
    end
    steady = 1'b0;

    repeat (20) @(negedge clk);
    $display("Checked %0d draws, %0d of them seeding, over %0d seed settings",
             tracker.checked, tracker.seedings, seed_settings);
    if (tracker.mismatches == 0 && tracker.expected_draws.size() == 0) begin
      $display("PASS");
    end else begin
      $display("Mismatches: %0d, draws still owed: %0d",
               tracker.mismatches, tracker.expected_draws.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
